### sv/salc_pkg.sv
// Shared types, codes and defaults of the set-associative LRU cache model.
`default_nettype none

package salc_pkg;

    // Default build parameters
    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_WAYS         = 8;
    localparam int DEF_ADDR_WIDTH   = 64;

    localparam int CNT_W       = 32;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 2;

    // Request type codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;
    localparam logic [1:0] REQ_IFETCH = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET   = 2'd2;

    // Configuration reset values
    localparam logic [3:0] SET_BITS_RST = 4'd4;
    localparam logic [3:0] WAYS_RST     = 4'd1;
    localparam logic [5:0] OFFSET_RST   = 6'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] access_addr;
    } salc_req_t;

    typedef struct packed {
        logic             was_hit;
        logic             was_miss;
        logic             was_eviction;
        logic [1:0]       hits_added;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } salc_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_MATCH,
        ST_UPDATE
    } salc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic row_read;
        logic match;
        logic commit;
    } salc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic req_fetch;
        logic out_busy;
    } salc_status_t;

endpackage

`default_nettype wire

### sv/salc_ctrl.sv
// Sequencing controller: clearing pass, request acceptance and per-access steps.
`default_nettype none

module salc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire salc_pkg::salc_status_t status,
    output salc_pkg::salc_cmd_t         cmd
);
    import salc_pkg::*;

    salc_state_t state_reg;
    salc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    // instruction fetches are dropped on transfer
                    if (!status.req_fetch)
                    begin
                        state_next = ST_INDEX;
                    end
                end
            end
            ST_INDEX:
            begin
                cmd.row_read = 1'b1;
                state_next   = ST_MATCH;
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold until the result register can take the result
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/salc_dpath.sv
// Datapath: configuration, set rows in memory, match and LRU update, totals, result register.
`default_nettype none

module salc_dpath #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int WAYS         = salc_pkg::DEF_WAYS,
    parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire salc_pkg::salc_cmd_t                  cmd,
    output salc_pkg::salc_status_t                    status,
    input  wire salc_pkg::salc_req_t                  req,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_ready,
    output salc_pkg::salc_rsp_t                       rsp,
    input  wire logic                                 cfg_we,
    input  wire logic [salc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import salc_pkg::*;

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W    = WAY_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
    localparam logic [3:0] SET_BITS_MAX = 4'(MAX_SET_BITS);

    // Configuration registers
    logic [3:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [5:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= SET_BITS_RST;
            ways_reg     <= WAYS_RST;
            offset_reg   <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS: set_bits_reg <= cfg_data[3:0];
                CFG_WAYS:     ways_reg     <= cfg_data[3:0];
                CFG_OFFSET:   offset_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    logic [3:0]      sbits_eff;
    logic [WAYS-1:0] in_use;

    always_comb
    begin
        sbits_eff = (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_reg;
        // a zero way count acts as one way
        for (int w = 0; w < WAYS; w++)
        begin
            in_use[w] = (w == 0) || (w < int'(ways_reg));
        end
    end

    // Captured request
    salc_req_t req_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
    end

    // Set index and tag
    logic [ADDR_WIDTH-1:0] addr;
    logic [ADDR_WIDTH-1:0] addr_shifted;
    logic [SET_IDX_W-1:0]  set_mask;
    logic [SET_IDX_W-1:0]  rd_set;
    logic [6:0]            tag_shamt;
    logic [ADDR_WIDTH-1:0] tag_calc;

    always_comb
    begin
        addr         = req_reg.access_addr[ADDR_WIDTH-1:0];
        addr_shifted = addr >> offset_reg;
        for (int i = 0; i < SET_IDX_W; i++)
        begin
            set_mask[i] = (i < int'(sbits_eff));
        end
        rd_set    = addr_shifted[SET_IDX_W-1:0] & set_mask;
        tag_shamt = 7'(offset_reg) + 7'(sbits_eff);
        tag_calc  = addr >> tag_shamt;
    end

    logic [SET_IDX_W-1:0]  set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.row_read)
        begin
            set_reg <= rd_set;
            tag_reg <= tag_calc;
        end
    end

    // Set rows: tags, valid bits and LRU ranks
    logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_mem   [NUM_SETS];
    logic [WAYS-1:0]                 valid_mem [NUM_SETS];
    logic [WAYS-1:0][RANK_W-1:0]     rank_mem  [NUM_SETS];

    logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_row_reg;
    logic [WAYS-1:0]                 valid_row_reg;
    logic [WAYS-1:0][RANK_W-1:0]     rank_row_reg;

    logic [SET_IDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Match step
    logic [WAYS-1:0]   match_vec;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              have_free;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  lru_way;
    logic [RANK_W-1:0] lru_best;

    always_comb
    begin
        hit       = 1'b0;
        hit_way   = '0;
        have_free = 1'b0;
        free_way  = '0;
        lru_best  = '0;
        lru_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match_vec[w] = in_use[w] && valid_row_reg[w] && (tag_row_reg[w] == tag_reg);
        end
        // scan downward so the lowest-numbered way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match_vec[w])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (in_use[w] && !valid_row_reg[w])
            begin
                have_free = 1'b1;
                free_way  = WAY_W'(w);
            end
        end
        // largest rank, ties to the lowest way
        for (int w = 0; w < WAYS; w++)
        begin
            if (in_use[w] && ((w == 0) || (rank_row_reg[w] > lru_best)))
            begin
                lru_best = rank_row_reg[w];
                lru_way  = WAY_W'(w);
            end
        end
    end

    logic              hit_reg;
    logic              evict_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [RANK_W-1:0] hrank_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            hit_reg   <= hit;
            evict_reg <= !hit && !have_free;
            way_reg   <= hit ? hit_way : (have_free ? free_way : lru_way);
            hrank_reg <= rank_row_reg[hit_way];
        end
    end

    // Update step
    logic [WAYS-1:0]                 new_valid;
    logic [WAYS-1:0][RANK_W-1:0]     new_rank;
    logic [WAYS-1:0][ADDR_WIDTH-1:0] new_tag_row;

    always_comb
    begin
        new_valid   = valid_row_reg;
        new_rank    = rank_row_reg;
        new_tag_row = tag_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == way_reg)
            begin
                new_valid[w]   = 1'b1;
                new_rank[w]    = '0;
                new_tag_row[w] = tag_reg;
            end
            else if (in_use[w] && valid_row_reg[w]
                     && (hit_reg ? (rank_row_reg[w] < hrank_reg)
                                 : (rank_row_reg[w] < RANK_MAX)))
            begin
                new_rank[w] = rank_row_reg[w] + 1'b1;
            end
        end
    end

    logic                 meta_we;
    logic [SET_IDX_W-1:0] meta_set;
    logic [WAYS-1:0]      meta_valid;
    logic [WAYS-1:0][RANK_W-1:0] meta_rank;

    always_comb
    begin
        meta_we    = cmd.clear_wr || cmd.commit;
        meta_set   = cmd.clear_wr ? clr_cnt_reg : set_reg;
        meta_valid = cmd.clear_wr ? '0 : new_valid;
        meta_rank  = cmd.clear_wr ? '0 : new_rank;
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            valid_mem[meta_set] <= meta_valid;
            rank_mem[meta_set]  <= meta_rank;
        end
        if (cmd.commit && !hit_reg)
        begin
            tag_mem[set_reg] <= new_tag_row;
        end
        if (cmd.row_read)
        begin
            tag_row_reg   <= tag_mem[rd_set];
            valid_row_reg <= valid_mem[rd_set];
            rank_row_reg  <= rank_mem[rd_set];
        end
    end

    // Running totals, saturating
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] evict_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_next;
    logic [CNT_W-1:0] evict_cnt_next;
    logic [1:0]       hits_added;
    logic [CNT_W:0]   hit_sum;

    always_comb
    begin
        hits_added = {1'b0, hit_reg} + {1'b0, (req_reg.req_type == REQ_MODIFY)};
        hit_sum    = {1'b0, hit_cnt_reg} + (CNT_W + 1)'(hits_added);
        hit_cnt_next = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
        miss_cnt_next = miss_cnt_reg;
        if (!hit_reg && (miss_cnt_reg != '1))
        begin
            miss_cnt_next = miss_cnt_reg + 1'b1;
        end
        evict_cnt_next = evict_cnt_reg;
        if (evict_reg && (evict_cnt_reg != '1))
        begin
            evict_cnt_next = evict_cnt_reg + 1'b1;
        end
    end

    logic      rsp_valid_reg;
    salc_rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.was_hit        <= hit_reg;
            rsp_reg.was_miss       <= !hit_reg;
            rsp_reg.was_eviction   <= evict_reg;
            rsp_reg.hits_added     <= hits_added;
            rsp_reg.hit_total      <= hit_cnt_next;
            rsp_reg.miss_total     <= miss_cnt_next;
            rsp_reg.eviction_total <= evict_cnt_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign status.clear_last = (clr_cnt_reg == SET_IDX_W'(NUM_SETS - 1));
    assign status.req_fetch  = (req.req_type == REQ_IFETCH);
    assign status.out_busy   = rsp_valid_reg && !rsp_ready;

endmodule

`default_nettype wire

### sv/set_assoc_lru_cache_sim.sv
// Top level of the set-associative cache model with true LRU replacement.
`default_nettype none

// Each load, store or modify access gives one result with hit, miss and eviction
// flags and saturating running totals; instruction fetches are taken and dropped.
// One access at a time: a data access holds the block through its steps (transfer,
// set row read, tag match, LRU update and write back), and its result reaches
// the output register in the update step. The set rows are read into registers
// before the match, and the match outcome is registered before the update. An
// instruction fetch leaves the block ready for the next access. A result waits
// in the output register while the next access is taken, and the update step
// holds while that register is still full. After reset, the valid and rank rows
// are cleared one set per cycle, all 2**MAX_SET_BITS sets, with req_ready low;
// configuration writes are taken at any time.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int WAYS         = salc_pkg::DEF_WAYS,
    parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire salc_pkg::salc_req_t              req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output salc_pkg::salc_rsp_t                   rsp,
    input  wire logic                             cfg_we,
    input  wire logic [salc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import salc_pkg::*;

    salc_cmd_t    cmd;
    salc_status_t status;

    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    salc_dpath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

### tb/set_assoc_lru_cache_sim_tb.sv
// Self-checking testbench for the set-associative LRU cache model.
`timescale 1ns / 100ps

module set_assoc_lru_cache_sim_tb;

    import salc_pkg::*;

    localparam int MAX_SET_BITS = DEF_MAX_SET_BITS;
    localparam int WAYS         = DEF_WAYS;
    localparam int ADDR_WIDTH   = DEF_ADDR_WIDTH;
    localparam int LINES        = (1 << MAX_SET_BITS) * WAYS;
    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    salc_req_t              req       = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    salc_rsp_t              rsp;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SET_BITS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow copy of the cache: tags, valid bits, LRU ranks, totals, registers
    logic [63:0]      tag_mem  [LINES];
    bit               line_vld [LINES];
    logic [2:0]       rank_mem [LINES];
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] miss_cnt;
    logic [CNT_W-1:0] evict_cnt;
    logic [3:0]       cfg_set_bits;
    logic [3:0]       cfg_ways;
    logic [5:0]       cfg_offset;

    salc_rsp_t outcome_q[$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        burst_left[2] = '{0, 0};

    set_assoc_lru_cache_sim u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic int eff_set_bits();
        return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
    endfunction

    function automatic int eff_ways();
        return (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : int'(cfg_ways));
    endfunction

    task automatic clear_cache();
        for (int i = 0; i < LINES; i++)
        begin
            tag_mem[i]  = '0;
            line_vld[i] = 1'b0;
            rank_mem[i] = '0;
        end
        hit_cnt      = '0;
        miss_cnt     = '0;
        evict_cnt    = '0;
        cfg_set_bits = SET_BITS_RST;
        cfg_ways     = WAYS_RST;
        cfg_offset   = OFFSET_RST;
    endtask

    // Look up one access, update the shadow cache and return its outcome
    function automatic bit cache_access(input salc_req_t r, output salc_rsp_t o);
        int          sb;
        int          nw;
        int          base;
        int          hway;
        int          victim;
        logic [63:0] set_idx;
        logic [63:0] tag;
        logic [2:0]  hrank;
        logic [2:0]  best;
        bit          hit;
        bit          evict;
        bit          found;
        o      = '0;
        hit    = 1'b0;
        evict  = 1'b0;
        found  = 1'b0;
        hway   = 0;
        victim = 0;
        if (r.req_type == REQ_IFETCH)
            return 1'b0;
        sb = eff_set_bits();
        nw = eff_ways();
        set_idx = (cfg_offset >= ADDR_WIDTH) ? 64'd0 :
                  ((r.access_addr >> cfg_offset) & ((64'd1 << sb) - 64'd1));
        tag = (cfg_offset + sb >= ADDR_WIDTH) ? 64'd0 : (r.access_addr >> (cfg_offset + sb));
        base = int'(set_idx[MAX_SET_BITS-1:0]) * WAYS;

        for (int w = 0; w < nw; w++)
            if (!hit && line_vld[base+w] && tag_mem[base+w] == tag)
            begin
                hit  = 1'b1;
                hway = w;
            end

        if (hit)
        begin
            hrank = rank_mem[base+hway];
            for (int w = 0; w < nw; w++)
                if (w != hway && line_vld[base+w] && rank_mem[base+w] < hrank)
                    rank_mem[base+w]++;
            rank_mem[base+hway] = '0;
            hit_cnt = sat_inc(hit_cnt);
        end
        else
        begin
            for (int w = 0; w < nw; w++)
                if (!found && !line_vld[base+w])
                begin
                    found  = 1'b1;
                    victim = w;
                end
            // Full set: take the largest rank, lowest way on a tie
            if (!found)
            begin
                evict = 1'b1;
                best  = '0;
                for (int w = 0; w < nw; w++)
                    if (rank_mem[base+w] > best || w == 0)
                    begin
                        best   = rank_mem[base+w];
                        victim = w;
                    end
            end
            for (int w = 0; w < nw; w++)
                if (w != victim && line_vld[base+w] && rank_mem[base+w] < WAYS - 1)
                    rank_mem[base+w]++;
            tag_mem[base+victim]  = tag;
            line_vld[base+victim] = 1'b1;
            rank_mem[base+victim] = '0;
            miss_cnt = sat_inc(miss_cnt);
            if (evict)
                evict_cnt = sat_inc(evict_cnt);
        end

        if (r.req_type == REQ_MODIFY)
            hit_cnt = sat_inc(hit_cnt);

        o.was_hit        = hit;
        o.was_miss       = !hit;
        o.was_eviction   = evict;
        o.hits_added     = 2'(hit) + 2'(r.req_type == REQ_MODIFY);
        o.hit_total      = hit_cnt;
        o.miss_total     = miss_cnt;
        o.eviction_total = evict_cnt;
        return 1'b1;
    endfunction

    // Track register writes and accepted accesses
    always @(posedge clk or negedge rst_n)
    begin : track_access
        salc_rsp_t o;
        if (!rst_n)
            clear_cache();
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_SET_BITS: cfg_set_bits = cfg_data[3:0];
                    CFG_WAYS:     cfg_ways     = cfg_data[3:0];
                    CFG_OFFSET:   cfg_offset   = cfg_data[5:0];
                    default: ;
                endcase
            if (req_valid && req_ready)
                if (cache_access(req, o))
                    outcome_q.push_back(o);
        end
    end

    always @(posedge clk)
    begin : check_rsp
        salc_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no access pending", $realtime);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (rsp.was_hit !== want.was_hit || rsp.was_miss !== want.was_miss ||
                    rsp.was_eviction !== want.was_eviction ||
                    rsp.hits_added !== want.hits_added ||
                    rsp.hit_total !== want.hit_total ||
                    rsp.miss_total !== want.miss_total ||
                    rsp.eviction_total !== want.eviction_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: exp h/m/e %0b%0b%0b add %0d tot %0d/%0d/%0d, %s",
                                 $realtime, want.was_hit, want.was_miss,
                                 want.was_eviction, want.hits_added, want.hit_total,
                                 want.miss_total, want.eviction_total,
                                 $sformatf("got h/m/e %0b%0b%0b add %0d tot %0d/%0d/%0d",
                                           rsp.was_hit, rsp.was_miss, rsp.was_eviction,
                                           rsp.hits_added, rsp.hit_total,
                                           rsp.miss_total, rsp.eviction_total));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Cycles to hold off before the next transfer; occasional runs with no gaps
    function automatic int draw_wait(input int side);
        if (burst_left[side] > 0)
        begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst_left[side] = $urandom_range(20, 60);
            return 0;
        end
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
    endfunction

    initial
    begin : drain_rsp
        int stall;
        forever
        begin
            stall = draw_wait(1);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // Leaves valid high after the transfer; settle() or a gap drawn by the next call drops it
    task automatic send_access(input logic [1:0] kind, input logic [63:0] addr);
        int gap;
        gap = draw_wait(0);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{req_type: kind, access_addr: addr};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Wait until every outcome has arrived and the block has gone quiet
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] sb, input logic [3:0] nw,
                              input logic [5:0] off);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SET_BITS;
        cfg_data  <= {2'($urandom), sb};
        @(posedge clk);
        cfg_index <= CFG_WAYS;
        cfg_data  <= {2'($urandom), nw};
        @(posedge clk);
        cfg_index <= CFG_OFFSET;
        cfg_data  <= off;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Address for a given tag and set under the current geometry, random offset
    function automatic logic [63:0] make_addr(input logic [63:0] tag,
                                              input logic [63:0] set_sel);
        int          sb;
        logic [63:0] a;
        sb = eff_set_bits();
        a  = {$urandom, $urandom} & ((64'd1 << cfg_offset) - 64'd1);
        a |= (set_sel & ((64'd1 << sb) - 64'd1)) << cfg_offset;
        if (cfg_offset + sb < ADDR_WIDTH)
            a |= tag << (cfg_offset + sb);
        return a;
    endfunction

    task automatic test_default_config();
        send_access(REQ_LOAD,   64'h0);
        send_access(REQ_LOAD,   64'hF);
        send_access(REQ_STORE,  64'h0);
        send_access(REQ_MODIFY, 64'h0);
        send_access(REQ_IFETCH, 64'h0);
        send_access(REQ_MODIFY, 64'h100);
        send_access(REQ_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
        send_access(REQ_STORE,  64'h8000_0000_0000_0000);
    endtask

    task automatic test_lru_order();
        settle();
        set_config(4'd2, 4'd4, 6'd6);
        for (int t = 1; t <= 4; t++)
            send_access(REQ_LOAD, make_addr(64'(t), 64'd0));
        send_access(REQ_LOAD,   make_addr(64'd1, 64'd0));
        send_access(REQ_STORE,  make_addr(64'd5, 64'd0));
        send_access(REQ_LOAD,   make_addr(64'd2, 64'd0));
        send_access(REQ_MODIFY, make_addr(64'd1, 64'd0));
    endtask

    // Shrink then regrow the ways so one set holds the same tag twice
    task automatic test_duplicate_tags();
        settle();
        set_config(4'd0, 4'd2, 6'd0);
        send_access(REQ_LOAD, 64'h1234);
        send_access(REQ_LOAD, 64'h5678);
        settle();
        set_config(4'd0, 4'd1, 6'd0);
        send_access(REQ_STORE, 64'h5678);
        settle();
        set_config(4'd0, 4'd2, 6'd0);
        send_access(REQ_LOAD, 64'h5678);
        send_access(REQ_LOAD, 64'h9ABC);
    endtask

    task automatic test_config_extremes();
        settle();
        set_config(4'd15, 4'd15, 6'd63);
        send_access(REQ_LOAD,   64'h0);
        send_access(REQ_LOAD,   64'h8000_0000_0000_0000);
        send_access(REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        settle();
        set_config(4'd8, 4'd8, 6'd32);
        send_access(REQ_LOAD,  64'hDEAD_BEEF_0000_00FF);
        send_access(REQ_STORE, 64'hDEAD_BEEF_1234_56FF);
        send_access(REQ_LOAD,  64'h5555_AAAA_0000_00FF);
    endtask

    task automatic test_random_traffic();
        int          items_sent;
        int          phase_len;
        logic [3:0]  sb;
        logic [3:0]  nw;
        logic [5:0]  off;
        logic [1:0]  kind;
        logic [63:0] addr;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 5))
                0:       sb = 4'd0;
                1:       sb = 4'd8;
                2:       sb = 4'($urandom_range(9, 15));
                default: sb = 4'($urandom_range(1, 3));
            endcase
            nw = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
            case ($urandom_range(0, 6))
                0:       off = 6'd0;
                1:       off = 6'd32;
                2:       off = 6'd63;
                3:       off = 6'($urandom_range(0, 63));
                default: off = 6'($urandom_range(2, 8));
            endcase
            set_config(sb, nw, off);
            phase_len = $urandom_range(30, 90);
            for (int i = 0; i < phase_len; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // Small tag pool over a few sets keeps hits and evictions frequent
                    kind = ($urandom_range(0, 9) == 0) ? REQ_IFETCH
                                                       : 2'($urandom_range(REQ_LOAD, REQ_MODIFY));
                    addr = make_addr(64'($urandom_range(0, eff_ways() + 2)),
                                     64'($urandom_range(0, 3)));
                end
                else
                begin
                    kind = 2'($urandom_range(REQ_LOAD, REQ_IFETCH));
                    addr = {$urandom, $urandom};
                end
                items_sent++;
                send_access(kind, addr);
            end
        end
    endtask

    initial
    begin : run_tests
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_lru_order();
        test_duplicate_tags();
        test_config_extremes();
        test_random_traffic();
        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
